>>> src/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// LCD line timing package
// Shared widths, default timing constants, mode and register codes, and the
// structs passed between the timing step and the top level.
// ----------------------------------------------------------------------------
package lcdt_pkg;

	// Field and state widths.
	localparam int CNT_W     = 10;
	localparam int LINE_W    = 8;
	localparam int CLK_W     = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;

	// Default line timing.
	localparam int DOTS_PER_LINE_DEF = 456;
	localparam int VISIBLE_LINES_DEF = 144;
	localparam int LAST_LINE_DEF     = 153;

	// Length of the OAM search and pixel transfer periods in dots.
	localparam int OAM_DOTS  = 80;
	localparam int XFER_DOTS = 172;

	// LCD mode codes.
	localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LYC        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_IE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_IE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OAM_IE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LYC_IE     = 3'd5;

	// Configuration register contents.
	typedef struct packed {
		logic              display_enable;
		logic [LINE_W-1:0] lyc_compare;
		logic              hblank_irq_enable;
		logic              vblank_stat_irq_enable;
		logic              oam_irq_enable;
		logic              lyc_irq_enable;
	} lcdt_cfg_t;

	// Per-item status flags.
	typedef struct packed {
		logic coincidence;
		logic vblank_irq;
		logic stat_irq;
		logic draw_line;
	} lcdt_flags_t;

endpackage

>>> src/lcd_line_timing_controller.sv
// ----------------------------------------------------------------------------
// LCD line timing controller
// Paces scanlines from elapsed clock counts and reports line, LCD mode,
// line compare and the V-Blank, stat and draw pulses for each item.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle unless out_stall holds; the timing state updates
// as an item moves between the two, so each step is one pass.
// Reset: all configuration registers clear to zero, the countdown loads
// DOTS_PER_LINE, the line and mode clear, and both pipeline stages empty.
module lcd_line_timing_controller #(
	parameter int DOTS_PER_LINE = lcdt_pkg::DOTS_PER_LINE_DEF,
	parameter int VISIBLE_LINES = lcdt_pkg::VISIBLE_LINES_DEF,
	parameter int LAST_LINE     = lcdt_pkg::LAST_LINE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [lcdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcdt_pkg::CFG_W-1:0]        cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lcdt_pkg::CLK_W-1:0]        elapsed_clocks,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lcdt_pkg::LINE_W-1:0]       line,
	output logic [lcdt_pkg::MODE_W-1:0]       lcd_mode,
	output logic                              coincidence,
	output logic                              vblank_irq,
	output logic                              stat_irq,
	output logic                              draw_line
);
	import lcdt_pkg::*;

	localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(DOTS_PER_LINE);
	localparam logic [LINE_W-1:0] LAST_L    = LINE_W'(LAST_LINE);
	localparam logic [LINE_W-1:0] VIS_L     = LINE_W'(VISIBLE_LINES);

	lcdt_cfg_t          cfg_q;
	logic               valid_s1;
	logic [CLK_W-1:0]   clocks_s1;
	logic               out_valid_q;
	logic [LINE_W-1:0]  line_out_q;
	logic [MODE_W-1:0]  mode_out_q;
	lcdt_flags_t        flags_out_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LINE_W-1:0]  line_q;
	logic [MODE_W-1:0]  mode_q;
	logic [CNT_W-1:0]   cnt_d;
	logic [LINE_W-1:0]  line_d;
	logic [MODE_W-1:0]  mode_d;
	lcdt_flags_t        flags_d;
	logic               in_take;
	logic               advance_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DISPLAY_EN: cfg_q.display_enable         <= cfg_data[0];
				CFG_LYC:        cfg_q.lyc_compare            <= cfg_data[LINE_W-1:0];
				CFG_HBLANK_IE:  cfg_q.hblank_irq_enable      <= cfg_data[0];
				CFG_VBLANK_IE:  cfg_q.vblank_stat_irq_enable <= cfg_data[0];
				CFG_OAM_IE:     cfg_q.oam_irq_enable         <= cfg_data[0];
				CFG_LYC_IE:     cfg_q.lyc_irq_enable         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is free
	// or being emptied in the same cycle.
	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && out_valid_q && out_stall;
	assign in_take    = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			clocks_s1 <= elapsed_clocks;
		end
	end

	// Timing step for the item in the input register.
	lcdt_step #(
		.DOTS_PER_LINE (DOTS_PER_LINE),
		.VISIBLE_LINES (VISIBLE_LINES),
		.LAST_LINE     (LAST_LINE)
	) u_step (
		.cfg      (cfg_q),
		.clocks   (clocks_s1),
		.cnt_cur  (cnt_q),
		.line_cur (line_q),
		.mode_cur (mode_q),
		.cnt_nxt  (cnt_d),
		.line_nxt (line_d),
		.mode_nxt (mode_d),
		.flags    (flags_d)
	);

	// Timing state, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_RESET;
			line_q <= '0;
			mode_q <= MODE_HBLANK;
		end else if (advance_s1) begin
			cnt_q  <= cnt_d;
			line_q <= line_d;
			mode_q <= mode_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			line_out_q  <= line_d;
			mode_out_q  <= mode_d;
			flags_out_q <= flags_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign line        = line_out_q;
	assign lcd_mode    = mode_out_q;
	assign coincidence = flags_out_q.coincidence;
	assign vblank_irq  = flags_out_q.vblank_irq;
	assign stat_irq    = flags_out_q.stat_irq;
	assign draw_line   = flags_out_q.draw_line;

	// The countdown never holds more than one full line of dots.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_RESET)
		else $error("line countdown above one line of dots");

	// The reported line never goes past the last line.
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> line_out_q <= LAST_L)
		else $error("line past the last line");

	// A V-Blank pulse comes only with the first non-visible line.
	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && flags_out_q.vblank_irq) |-> line_out_q == VIS_L)
		else $error("vblank pulse on the wrong line");

	// Drawing and V-Blank never start on the same line.
	a_draw_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(flags_out_q.vblank_irq && flags_out_q.draw_line))
		else $error("draw and vblank pulse together");

	// The state only moves when an item passes into the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> $stable(line_q) && $stable(mode_q))
		else $error("timing state changed without an item");

endmodule

>>> src/lcdt_step.sv
// ----------------------------------------------------------------------------
// LCD line timing step
// Combinational next-state function for one timing item: derives the mode,
// checks the line compare, consumes the elapsed clocks and advances the line.
// ----------------------------------------------------------------------------
module lcdt_step #(
	parameter int DOTS_PER_LINE = lcdt_pkg::DOTS_PER_LINE_DEF,
	parameter int VISIBLE_LINES = lcdt_pkg::VISIBLE_LINES_DEF,
	parameter int LAST_LINE     = lcdt_pkg::LAST_LINE_DEF
) (
	input  lcdt_pkg::lcdt_cfg_t               cfg,
	input  logic [lcdt_pkg::CLK_W-1:0]        clocks,
	input  logic [lcdt_pkg::CNT_W-1:0]        cnt_cur,
	input  logic [lcdt_pkg::LINE_W-1:0]       line_cur,
	input  logic [lcdt_pkg::MODE_W-1:0]       mode_cur,
	output logic [lcdt_pkg::CNT_W-1:0]        cnt_nxt,
	output logic [lcdt_pkg::LINE_W-1:0]       line_nxt,
	output logic [lcdt_pkg::MODE_W-1:0]       mode_nxt,
	output lcdt_pkg::lcdt_flags_t             flags
);
	import lcdt_pkg::*;

	// Signed arithmetic width: holds countdown, bounds and the reload sum.
	localparam int SW = CNT_W + 2;

	localparam logic signed [SW-1:0] OAM_BOUND  = SW'(DOTS_PER_LINE - OAM_DOTS);
	localparam logic signed [SW-1:0] XFER_BOUND = SW'(DOTS_PER_LINE - OAM_DOTS - XFER_DOTS);
	localparam logic signed [SW-1:0] RELOAD     = SW'(DOTS_PER_LINE);
	localparam logic [LINE_W-1:0]    VIS_LINE   = LINE_W'(VISIBLE_LINES);
	localparam logic [LINE_W:0]      VIS_NEXT   = (LINE_W + 1)'(VISIBLE_LINES);
	localparam logic [LINE_W:0]      LAST_NEXT  = (LINE_W + 1)'(LAST_LINE);

	logic signed [SW-1:0] cnt_s;
	logic signed [SW-1:0] cnt_sub;
	logic signed [SW-1:0] cnt_adj;
	logic [LINE_W:0]      ly;
	logic                 req;
	logic                 mode_irq;
	logic                 advance;

	always_comb begin
		cnt_s   = SW'(cnt_cur);
		cnt_sub = cnt_s - SW'(clocks);
		advance = (cnt_sub <= 0);
		ly      = {1'b0, line_cur} + 1'b1;
		cnt_nxt = RELOAD[CNT_W-1:0];
		line_nxt = '0;
		mode_nxt = MODE_VBLANK;
		flags    = '0;
		req      = 1'b0;
		mode_irq = 1'b0;
		cnt_adj  = cnt_sub;

		if (cfg.display_enable) begin
			// Mode from the line and the position inside the line.
			if (line_cur >= VIS_LINE) begin
				mode_nxt = MODE_VBLANK;
				req      = cfg.vblank_stat_irq_enable;
			end else if (cnt_s >= OAM_BOUND) begin
				mode_nxt = MODE_OAM;
				req      = cfg.oam_irq_enable;
			end else if (cnt_s >= XFER_BOUND) begin
				mode_nxt = MODE_XFER;
				req      = 1'b0;
			end else begin
				mode_nxt = MODE_HBLANK;
				req      = cfg.hblank_irq_enable;
			end
			mode_irq = req && (mode_nxt != mode_cur);

			// Line compare.
			flags.coincidence = (line_cur == cfg.lyc_compare);
			flags.stat_irq    = mode_irq || (flags.coincidence && cfg.lyc_irq_enable);

			// End of line: advance, reload and wrap after the last line.
			line_nxt = line_cur;
			if (advance) begin
				cnt_adj = cnt_sub + RELOAD;
				if (ly == VIS_NEXT) begin
					flags.vblank_irq = 1'b1;
				end else if (ly > LAST_NEXT) begin
					ly = '0;
				end
				flags.draw_line = (ly < VIS_NEXT);
				line_nxt        = ly[LINE_W-1:0];
			end

			// A reload that is still not positive saturates at zero.
			if (cnt_adj < 0) begin
				cnt_nxt = '0;
			end else begin
				cnt_nxt = cnt_adj[CNT_W-1:0];
			end
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD line timing controller testbench
// Steps the block with elapsed clock counts under changing register settings.
// A directed table covers the disabled display, the mode boundaries, the line
// compare and the register masking. A long random run then follows, with
// frames that reach V-Blank and the line wrap. Every result is checked, field
// by field, against a predictor of the line timing that runs on each item
// accepted, or against the expected result of its directed row if typed.
// ----------------------------------------------------------------------------
module testbench;
	import lcdt_pkg::*;

	localparam int DOTS           = DOTS_PER_LINE_DEF;
	localparam int VISIBLE        = VISIBLE_LINES_DEF;
	localparam int LAST           = LAST_LINE_DEF;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int RESULT_LATENCY = 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;

	// Indexes with no register behind them; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

	// One result item: line, mode and the per-item flags.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [MODE_W-1:0] mode;
		lcdt_flags_t       flags;
	} line_status_t;

	localparam line_status_t NO_STATUS  = '0;
	localparam line_status_t OFF_STATUS = '{line: 8'd0, mode: MODE_VBLANK, flags: '0};

	typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [CLK_W-1:0]     clocks;
		logic                 typed;
		line_status_t         want;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} stim_row_t;

	// Directed stimulus. Typed rows carry their expected result; the others
	// are checked against the predictor.
	localparam int DIRECTED_COUNT = 33;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// Display disabled after reset: timing held, mode V-Blank.
		'{ROW_STEP,  8'd0,   1'b1, OFF_STATUS, CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b1, OFF_STATUS, CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd128, 1'b1, OFF_STATUS, CFG_DISPLAY_EN, 8'd0},
		// Enable everything, compare against line 0, poke the spare indexes.
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd1},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_LYC,        8'd0},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_HBLANK_IE,  8'd1},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_VBLANK_IE,  8'd1},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_OAM_IE,     8'd1},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_LYC_IE,     8'd1},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_SPARE_6,    8'hFF},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_SPARE_7,    8'hA5},
		// Walk the OAM, transfer and H-Blank boundaries, then advance lines.
		'{ROW_STEP,  8'd0,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd79,  1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd1,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd1,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd171, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd1,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd1,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		// Compare against line 2 with its interrupt off; upper data bits set.
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_LYC,        8'd2},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_LYC_IE,     8'hFE},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_HBLANK_IE,  8'hFE},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		// Disable mid-line: the timing drops back to its held state.
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'hFE},
		'{ROW_STEP,  8'd7,   1'b1, OFF_STATUS, CFG_DISPLAY_EN, 8'd0},
		'{ROW_WRITE, 8'd0,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd1},
		'{ROW_STEP,  8'd255, 1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0},
		'{ROW_STEP,  8'd0,   1'b0, NO_STATUS,  CFG_DISPLAY_EN, 8'd0}
	};

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [CLK_W-1:0]     elapsed_clocks = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [LINE_W-1:0]    line;
	logic [MODE_W-1:0]    lcd_mode;
	logic                 coincidence;
	logic                 vblank_irq;
	logic                 stat_irq;
	logic                 draw_line;

	// Predictor state and its copy of the registers.
	logic [CNT_W-1:0]  dot_left  = CNT_W'(DOTS);
	logic [LINE_W-1:0] line_now  = '0;
	logic [MODE_W-1:0] mode_cur  = MODE_HBLANK;
	lcdt_cfg_t         cfg_copy  = '0;

	line_status_t expected_status [$];
	int           error_count = 0;
	int           idle_cycles = 0;
	int           stall_run   = 0;
	int           burst_left  = 0;
	bit           results_pending = 1'b0;

	always #5 clk = ~clk;

	lcd_line_timing_controller #(
		.DOTS_PER_LINE(DOTS),
		.VISIBLE_LINES(VISIBLE),
		.LAST_LINE(LAST)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.elapsed_clocks(elapsed_clocks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line(line),
		.lcd_mode(lcd_mode),
		.coincidence(coincidence),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.draw_line(draw_line)
	);

	// Advance the line timing by one item and return the status it reports.
	function automatic line_status_t advance_timing(input logic [CLK_W-1:0] clocks);
		line_status_t      res;
		logic [MODE_W-1:0] prev;
		logic              req;
		int                cnt;
		int                ly;
		res = '0;
		if (!cfg_copy.display_enable) begin
			dot_left = CNT_W'(DOTS);
			line_now = '0;
			mode_cur = MODE_VBLANK;
		end else begin
			cnt  = int'(dot_left);
			prev = mode_cur;
			// The mode comes from the line and the countdown before the clocks.
			if (int'(line_now) >= VISIBLE) begin
				mode_cur = MODE_VBLANK;
				req      = cfg_copy.vblank_stat_irq_enable;
			end else if (cnt >= DOTS - OAM_DOTS) begin
				mode_cur = MODE_OAM;
				req      = cfg_copy.oam_irq_enable;
			end else if (cnt >= DOTS - OAM_DOTS - XFER_DOTS) begin
				mode_cur = MODE_XFER;
				req      = 1'b0;
			end else begin
				mode_cur = MODE_HBLANK;
				req      = cfg_copy.hblank_irq_enable;
			end
			res.flags.stat_irq = req && (mode_cur != prev);
			if (line_now == cfg_copy.lyc_compare) begin
				res.flags.coincidence = 1'b1;
				if (cfg_copy.lyc_irq_enable)
					res.flags.stat_irq = 1'b1;
			end
			// Consume the clocks; at most one line advances per item.
			cnt -= int'(clocks);
			if (cnt <= 0) begin
				ly   = int'(line_now) + 1;
				cnt += DOTS;
				if (ly == VISIBLE)
					res.flags.vblank_irq = 1'b1;
				else if (ly > LAST)
					ly = 0;
				if (ly < VISIBLE)
					res.flags.draw_line = 1'b1;
				line_now = ly[LINE_W-1:0];
			end
			if (cnt < 0)
				cnt = 0;
			dot_left = cnt[CNT_W-1:0];
		end
		res.line = line_now;
		res.mode = mode_cur;
		return res;
	endfunction

	// Present one item, hold it until accepted, then maybe leave a gap.
	task automatic push_step(input logic [CLK_W-1:0] clocks, input logic typed,
			input line_status_t want);
		line_status_t predicted;
		in_valid       <= 1'b1;
		elapsed_clocks <= clocks;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_timing(clocks);
		expected_status.push_back(typed ? want : predicted);
		results_pending = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid       <= 1'b0;
			elapsed_clocks <= CLK_W'($urandom_range(0, 255));
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(0, 8);
		end
	endtask

	// Wait until every expected result has come back and the pipe is empty.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2)
			@(posedge clk);
		results_pending = 1'b0;
	endtask

	// Write one register while the block is idle and mirror it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		if (results_pending)
			settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		case (index)
			CFG_DISPLAY_EN: cfg_copy.display_enable         = data[0];
			CFG_LYC:        cfg_copy.lyc_compare            = data;
			CFG_HBLANK_IE:  cfg_copy.hblank_irq_enable      = data[0];
			CFG_VBLANK_IE:  cfg_copy.vblank_stat_irq_enable = data[0];
			CFG_OAM_IE:     cfg_copy.oam_irq_enable         = data[0];
			CFG_LYC_IE:     cfg_copy.lyc_irq_enable         = data[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Receiver stalls in runs of its own, with long stall-free stretches.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			case ($urandom_range(0, 9))
				0: begin
					out_stall <= 1'b0;
					stall_run <= $urandom_range(40, 120);
				end
				1, 2, 3: begin
					out_stall <= 1'b1;
					stall_run <= $urandom_range(1, 12);
				end
				default: begin
					out_stall <= 1'b0;
					stall_run <= $urandom_range(1, 6);
				end
			endcase
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	// Compare each result item with the oldest expectation.
	always @(posedge clk) begin : check_results
		line_status_t want;
		line_status_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {line, lcd_mode, coincidence, vblank_irq, stat_irq, draw_line};
			if (expected_status.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: result item with none expected, actual %h", $time, got);
				error_count++;
			end else begin
				want = expected_status.pop_front();
				check_field("line", want.line, got.line);
				check_field("lcd_mode", want.mode, got.mode);
				check_field("coincidence", want.flags.coincidence, got.flags.coincidence);
				check_field("vblank_irq", want.flags.vblank_irq, got.flags.vblank_irq);
				check_field("stat_irq", want.flags.stat_irq, got.flags.stat_irq);
				check_field("draw_line", want.flags.draw_line, got.flags.draw_line);
			end
		end
	end

	// Watchdog on cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [CFG_IDX_W-1:0] ie_regs [4];
		logic [CFG_W-1:0]     wr_data;
		logic [CLK_W-1:0]     clocks;
		logic                 display_on;
		int                   ie_pick;
		int                   phase_len;
		int                   sent;
		ie_regs = '{CFG_HBLANK_IE, CFG_VBLANK_IE, CFG_OAM_IE, CFG_LYC_IE};
		sent    = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_WRITE)
				write_reg(DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].data);
			else
				push_step(DIRECTED_ROWS[r].clocks, DIRECTED_ROWS[r].typed,
					DIRECTED_ROWS[r].want);
		end

		// Random phases, each under a fresh register setting.
		while (sent < RANDOM_ITEMS) begin
			display_on = ($urandom_range(0, 7) != 0);
			wr_data    = CFG_W'($urandom_range(0, 255));
			wr_data[0] = display_on;
			write_reg(CFG_DISPLAY_EN, wr_data);
			case ($urandom_range(0, 5))
				0:       wr_data = '0;
				1:       wr_data = CFG_W'(LAST);
				2:       wr_data = '1;
				3:       wr_data = CFG_W'(VISIBLE);
				4:       wr_data = CFG_W'($urandom_range(0, LAST));
				default: wr_data = CFG_W'($urandom_range(0, 255));
			endcase
			write_reg(CFG_LYC, wr_data);
			// Interrupt enables all off, all on, or mixed.
			ie_pick = $urandom_range(0, 3);
			foreach (ie_regs[k]) begin
				wr_data    = CFG_W'($urandom_range(0, 255));
				wr_data[0] = (ie_pick == 0) ? 1'b0 : (ie_pick == 1) ? 1'b1
				                                   : 1'($urandom_range(0, 1));
				write_reg(ie_regs[k], wr_data);
			end
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
					CFG_W'($urandom_range(0, 255)));

			// Enabled phases run long, and the timing carries on while the display stays on.
			phase_len = display_on ? $urandom_range(80, 260) : $urandom_range(4, 12);
			repeat (phase_len) begin
				case ($urandom_range(0, 19))
					0:             clocks = '0;
					1:             clocks = '1;
					2, 3:          clocks = CLK_W'($urandom_range(0, 15));
					4, 5, 6, 7, 8: clocks = CLK_W'($urandom_range(200, 255));
					default:       clocks = CLK_W'($urandom_range(0, 255));
				endcase
				push_step(clocks, 1'b0, NO_STATUS);
				sent++;
			end
		end

		// Drain, allow any stray result to show up, then report.
		settle_block();
		repeat (4 * RESULT_LATENCY)
			@(posedge clk);
		if (error_count == 0 && expected_status.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
src/lcdt_pkg.sv
src/lcdt_step.sv
src/lcd_line_timing_controller.sv
tb/testbench.sv
